[design/cdp_pkg.sv]
// shared types and constants for the coin change dp block
// beat structs, controller command and status structs, mode and register codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cdp_pkg;

	// fixed field widths
	localparam int VAL_W    = 10;
	localparam int CNT_W    = 10;
	localparam int SLOT_W   = 3;
	localparam int KINDS_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int PADDR_W  = 3;

	// beat modes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_CHANGE = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_COIN_KINDS = 1'b0;

	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] coin_slot;
		logic [VAL_W-1:0]  coin_value;
		logic [VAL_W-1:0]  amount;
	} in_beat_t;

	typedef struct packed {
		logic [VAL_W-1:0] denomination;
		logic [CNT_W-1:0] coins_used;
		logic             last;
	} out_beat_t;

	// controller to datapath
	typedef struct packed {
		logic load_coin;
		logic start;
		logic row0_wr;
		logic fill_issue;
		logic next_row;
		logic tb_load;
		logic tb_cur;
		logic tb_issue;
		logic tb_eval;
		logic emit_init;
		logic emit_pop;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic n_zero;
		logic j_last;
		logic row_is_n;
		logic tb_done;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[design/cdp_ctrl.sv]
// sequencer for the coin change block: table fill, traceback, result emit
// depends on cdp_pkg
`timescale 1ns / 1ps
`default_nettype none

module cdp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_accept,
	input  logic          in_mode,
	input  cdp_pkg::sts_t sts,
	output cdp_pkg::cmd_t cmd,
	output logic          busy
);
	import cdp_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_ROW0     = 10'b0000000010,
		ST_FILL     = 10'b0000000100,
		ST_DRAIN    = 10'b0000001000,
		ST_TB_LOAD  = 10'b0000010000,
		ST_TB_CUR   = 10'b0000100000,
		ST_TB_ISSUE = 10'b0001000000,
		ST_TB_EVAL  = 10'b0010000000,
		ST_EMIT_SET = 10'b0100000000,
		ST_EMIT     = 10'b1000000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					if (in_mode == MODE_LOAD) begin
						cmd.load_coin = 1'b1;
					end else begin
						cmd.start = 1'b1;
						if (!sts.n_zero) state_nxt = ST_ROW0;
					end
				end
			end
			ST_ROW0: begin
				cmd.row0_wr = 1'b1;
				if (sts.j_last) begin
					cmd.next_row = 1'b1;
					state_nxt    = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_issue = 1'b1;
				if (sts.j_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.row_is_n) begin
					state_nxt = ST_TB_LOAD;
				end else begin
					cmd.next_row = 1'b1;
					state_nxt    = ST_FILL;
				end
			end
			ST_TB_LOAD: begin
				cmd.tb_load = 1'b1;
				state_nxt   = ST_TB_CUR;
			end
			ST_TB_CUR: begin
				cmd.tb_cur = 1'b1;
				state_nxt  = ST_TB_ISSUE;
			end
			ST_TB_ISSUE: begin
				cmd.tb_issue = 1'b1;
				state_nxt    = ST_TB_EVAL;
			end
			ST_TB_EVAL: begin
				cmd.tb_eval = 1'b1;
				state_nxt   = sts.tb_done ? ST_EMIT_SET : ST_TB_ISSUE;
			end
			ST_EMIT_SET: begin
				cmd.emit_init = 1'b1;
				state_nxt     = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_pop = 1'b1;
					if (sts.emit_last) state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[design/cdp_datapath.sv]
// datapath for the coin change block: coin table, dp table memory, counters,
// traceback compare and the output register; depends on cdp_pkg
`timescale 1ns / 1ps
`default_nettype none

module cdp_datapath #(
	parameter int MAX_COINS  = 8,
	parameter int MAX_AMOUNT = 1023
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cdp_pkg::cmd_t                 cmd,
	output cdp_pkg::sts_t                 sts,
	input  cdp_pkg::in_beat_t             in_data,
	input  logic [cdp_pkg::KINDS_W-1:0]   coin_kinds,
	input  logic                          out_stall,
	output logic                          out_valid,
	output cdp_pkg::out_beat_t            out_data
);
	import cdp_pkg::*;

	localparam int ROWS    = MAX_COINS + 1;
	localparam int ROW_LEN = MAX_AMOUNT + 1;
	localparam int DEPTH   = ROWS * ROW_LEN;
	localparam int AW      = $clog2(DEPTH);
	localparam int RW      = $clog2(ROWS);
	localparam int CW      = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
	localparam logic [AW-1:0]    ROW_STEP = AW'(ROW_LEN);
	localparam logic [VAL_W-1:0] AMT_CAP  = (MAX_AMOUNT > 1023) ? {VAL_W{1'b1}}
		: VAL_W'(MAX_AMOUNT);

	// stored state
	logic [VAL_W-1:0] coin_table_q [MAX_COINS];
	logic [CNT_W-1:0] counts_q     [MAX_COINS];
	logic [VAL_W-1:0] dp_mem       [DEPTH];

	logic [RW-1:0]    n_q;
	logic [RW-1:0]    row_q;
	logic [VAL_W-1:0] t_q;
	logic [VAL_W-1:0] j_q;
	logic [AW-1:0]    base_prev_q;
	logic [AW-1:0]    base_cur_q;
	logic [VAL_W-1:0] cur_q;
	logic [VAL_W-1:0] rd_a_q;
	logic [VAL_W-1:0] rd_b_q;
	logic [VAL_W-1:0] last_v_q;

	// fill pipeline stage
	logic             fill_s1;
	logic [AW-1:0]    wa_s1;
	logic             use_sub_s1;
	logic             fwd_s1;

	logic             out_valid_q;
	out_beat_t        out_q;

	logic [RW-1:0]    row_dec;
	logic [CW-1:0]    cidx;
	logic [VAL_W-1:0] coin;
	logic [RW-1:0]    n_calc;
	logic [VAL_W-1:0] amt_sat;
	logic [VAL_W-1:0] idx_sel;
	logic [AW-1:0]    addr_a;
	logic [AW-1:0]    addr_b;
	logic [VAL_W-1:0] sub_v;
	logic [VAL_W:0]   sub_inc;
	logic [VAL_W-1:0] fill_v;
	logic             we;
	logic [AW-1:0]    wa;
	logic [VAL_W-1:0] wd;
	logic [VAL_W:0]   tb_inc;
	logic             cond_up;
	logic             cond_take;
	logic             out_free;

	// current coin, shared by fill, traceback and emit
	assign row_dec = row_q - RW'(1);
	assign cidx    = CW'(row_dec);
	assign coin    = coin_table_q[cidx];

	// request setup values
	assign n_calc  = (32'(coin_kinds) > MAX_COINS) ? RW'(MAX_COINS) : RW'(coin_kinds);
	assign amt_sat = (in_data.amount > AMT_CAP) ? AMT_CAP : in_data.amount;

	// memory read addresses
	assign idx_sel = (cmd.tb_load || cmd.tb_issue) ? t_q : j_q;
	assign addr_a  = (cmd.tb_load ? base_cur_q : base_prev_q) + AW'(idx_sel);
	assign addr_b  = base_cur_q + AW'(idx_sel) - AW'(coin);

	// fill cell: min of cell above and one more than the cell one coin back
	assign sub_v   = fwd_s1 ? last_v_q : rd_b_q;
	assign sub_inc = {1'b0, sub_v} + (VAL_W+1)'(1);
	assign fill_v  = (use_sub_s1 && (sub_inc < {1'b0, rd_a_q})) ? sub_inc[VAL_W-1:0]
		: rd_a_q;

	// memory write port
	assign we = cmd.row0_wr || fill_s1;
	assign wa = cmd.row0_wr ? AW'(j_q) : wa_s1;
	assign wd = cmd.row0_wr ? j_q : fill_v;

	// traceback decisions; rd_a holds the row above, rd_b the cell one coin back
	assign tb_inc    = {1'b0, rd_b_q} + (VAL_W+1)'(1);
	assign cond_up   = (coin != VAL_W'(1)) && (cur_q == rd_a_q);
	assign cond_take = (coin != '0) && (t_q >= coin) && ({1'b0, cur_q} == tb_inc);

	// dp table memory
	always_ff @(posedge clk) begin
		if (we) dp_mem[wa] <= wd;
		rd_a_q <= dp_mem[addr_a];
		rd_b_q <= dp_mem[addr_b];
	end

	// coin table writes
	always_ff @(posedge clk) begin
		if (cmd.load_coin && (32'(in_data.coin_slot) < MAX_COINS)) begin
			coin_table_q[CW'(in_data.coin_slot)] <= in_data.coin_value;
		end
	end

	// fill stage payload
	always_ff @(posedge clk) begin
		if (cmd.fill_issue) begin
			wa_s1      <= base_cur_q + AW'(j_q);
			use_sub_s1 <= (coin != '0) && (j_q >= coin);
			fwd_s1     <= (coin == VAL_W'(1));
		end
		if (fill_s1) last_v_q <= fill_v;
	end

	// traceback running count of the current cell
	always_ff @(posedge clk) begin
		if (cmd.tb_cur) begin
			cur_q <= rd_a_q;
		end else if (cmd.tb_eval) begin
			if (cond_up) begin
				cur_q <= rd_a_q;
			end else if (cond_take) begin
				cur_q <= rd_b_q;
			end
		end
	end

	// counters, row bases and fill stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			row_q       <= '0;
			t_q         <= '0;
			j_q         <= '0;
			base_prev_q <= '0;
			base_cur_q  <= '0;
			fill_s1     <= 1'b0;
		end else begin
			fill_s1 <= cmd.fill_issue;
			if (cmd.start) begin
				n_q         <= n_calc;
				row_q       <= '0;
				t_q         <= amt_sat;
				j_q         <= '0;
				base_prev_q <= '0;
				base_cur_q  <= '0;
			end
			if (cmd.row0_wr || cmd.fill_issue) j_q <= j_q + VAL_W'(1);
			if (cmd.next_row) begin
				row_q       <= row_q + RW'(1);
				j_q         <= '0;
				base_prev_q <= base_cur_q;
				base_cur_q  <= base_cur_q + ROW_STEP;
			end
			if (cmd.tb_eval) begin
				if (cond_up) begin
					row_q       <= row_dec;
					base_cur_q  <= base_prev_q;
					base_prev_q <= base_prev_q - ROW_STEP;
				end else if (cond_take) begin
					t_q <= t_q - coin;
				end
			end
			if (cmd.emit_init) row_q <= n_q;
			if (cmd.emit_pop) row_q <= row_dec;
		end
	end

	// per-coin result counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_COINS; k++) counts_q[k] <= '0;
		end else if (cmd.start) begin
			for (int k = 0; k < MAX_COINS; k++) counts_q[k] <= '0;
		end else if (cmd.tb_eval && !cond_up && cond_take) begin
			counts_q[cidx] <= counts_q[cidx] + CNT_W'(1);
		end
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pop) begin
			out_q.denomination <= coin;
			out_q.coins_used   <= counts_q[cidx];
			out_q.last         <= (row_q == RW'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status back to the controller
	always_comb begin
		sts           = '0;
		sts.n_zero    = (coin_kinds == '0);
		sts.j_last    = (j_q == t_q);
		sts.row_is_n  = (row_q == n_q);
		sts.tb_done   = cond_up ? (row_q == RW'(1)) : !cond_take;
		sts.emit_last = (row_q == RW'(1));
		sts.out_free  = out_free;
	end

endmodule

`default_nettype wire

[design/coin_change_dp_with_traceback.sv]
// sequence: a load beat is taken while idle; a change request for amount T over n coins writes
// row 0, then fills rows 1..n through the single write port of the dp table (one cell per
// cycle), then walks back with ST_TB_ISSUE and ST_TB_EVAL for each traceback step, then emits
// throughput: one request at a time; loads one per cycle while no request is in progress
// reset: controller idle, output empty, coin_kinds = 1; coin table and dp memory
// are not cleared (the dp table is filled before it is read on each request)
`timescale 1ns / 1ps
`default_nettype none

module coin_change_dp_with_traceback #(
	parameter int MAX_COINS  = 8,
	parameter int MAX_AMOUNT = 1023
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beats
	input  logic                          in_valid,
	output logic                          in_stall,
	input  cdp_pkg::in_beat_t             in_data,
	// result beats
	output logic                          out_valid,
	input  logic                          out_stall,
	output cdp_pkg::out_beat_t            out_data,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cdp_pkg::PADDR_W-1:0]   paddr,
	input  logic [cdp_pkg::PDATA_W-1:0]   pwdata,
	output logic [cdp_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import cdp_pkg::*;

	logic               busy;
	logic               in_accept;
	logic               cfg_wr;
	logic [KINDS_W-1:0] coin_kinds_q;
	cmd_t               cmd;
	sts_t               sts;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_kinds_q <= KINDS_W'(1);
		end else if (cfg_wr && (paddr[2] == REG_COIN_KINDS)) begin
			coin_kinds_q <= pwdata[KINDS_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_COIN_KINDS) ? PDATA_W'(coin_kinds_q) : '0;

	// input handshake
	assign in_stall  = busy;
	assign in_accept = in_valid && !in_stall;

	cdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_mode   (in_data.mode),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	cdp_datapath #(
		.MAX_COINS  (MAX_COINS),
		.MAX_AMOUNT (MAX_AMOUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_data    (in_data),
		.coin_kinds (coin_kinds_q),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

[design/cdp_checker.sv]
// port-level checks for the coin change block, bound to the top level
// depends on cdp_pkg and coin_change_dp_with_traceback
`timescale 1ns / 1ps
`default_nettype none

module cdp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input cdp_pkg::in_beat_t           in_data,
	input logic                        out_valid,
	input logic                        out_stall,
	input cdp_pkg::out_beat_t          out_data
);
	import cdp_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// results appear only while a request is in progress
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat raised outside a request");

	// a coin load never makes the block busy
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.mode == MODE_LOAD) |=> !in_stall)
		else $error("coin load stalled the input");

	// nothing follows the last beat of a request
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.last |=> !out_valid)
		else $error("result beat after last");

endmodule

bind coin_change_dp_with_traceback cdp_checker u_cdp_checker (.*);

`default_nettype wire

[tb/sv/coin_change_dp_with_traceback_test.sv]
// self-checking testbench for the coin change dp block with traceback
// drives load and change beats, predicts the per-coin counts, checks every result beat
// depends on cdp_pkg and coin_change_dp_with_traceback
`timescale 1ns / 1ps

module coin_change_dp_with_traceback_test;
	import cdp_pkg::*;

	localparam int COIN_SLOTS   = 8;
	localparam int TOP_AMOUNT   = 1023;
	localparam int SETTLE_TICKS = 1200;
	localparam int CYCLE_LIMIT  = 6000000;

	typedef enum logic [1:0] {ROW_LOAD, ROW_CHANGE, ROW_KINDS} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [9:0] arg_a;
		logic [9:0] arg_b;
		logic       typed;
		logic       typed_n;
		out_beat_t  typed_out;
	} script_row_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_beat_t            in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_beat_t           out_data;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [PADDR_W-1:0]  paddr     = '0;
	logic [PDATA_W-1:0]  pwdata    = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// shadow copy of the block state
	logic [VAL_W-1:0]    shadow_coins [COIN_SLOTS];
	logic [KINDS_W-1:0]  shadow_kinds = 4'd1;
	int                  min_coins [0:COIN_SLOTS][0:TOP_AMOUNT];

	out_beat_t           change_due [$];
	int                  mismatches = 0;
	int                  cycles     = 0;
	int                  gap_pct    = 0;
	int                  stall_pct  = 0;
	int                  stall_left = 0;

	script_row_t         script [$];

	coin_change_dp_with_traceback uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (stall_pct != 0 && int'($urandom_range(99, 0)) < stall_pct)
				stall_left <= int'($urandom_range(18, 1));
		end
	end

	function automatic void note_fault(string what, out_beat_t want, out_beat_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"mismatch %0s: expected denom %0d count %0d last %0d,",
				" got denom %0d count %0d last %0d"},
				what, want.denomination, want.coins_used, want.last,
				got.denomination, got.coins_used, got.last);
	endfunction

	// compare each accepted result beat with the oldest expectation
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (change_due.size() == 0) begin
				note_fault("unexpected beat", '0, out_data);
			end else begin
				want = change_due.pop_front();
				if (out_data.denomination != want.denomination)
					note_fault("denomination", want, out_data);
				else if (out_data.coins_used != want.coins_used)
					note_fault("coins_used", want, out_data);
				else if (out_data.last != want.last)
					note_fault("last", want, out_data);
			end
		end
	end

	// minimum-coin table fill and traceback, one result per coin slot in use
	function automatic void predict_beat(in_beat_t b, bit record);
		int n, t, d, c, v, s;
		int taken [COIN_SLOTS];
		bit walking;
		out_beat_t r;
		if (b.mode == MODE_LOAD) begin
			shadow_coins[b.coin_slot] = b.coin_value;
		end else begin
			n = (int'(shadow_kinds) > COIN_SLOTS) ? COIN_SLOTS : int'(shadow_kinds);
			t = int'(b.amount);
			for (int k = 0; k < COIN_SLOTS; k++)
				taken[k] = 0;
			if (n != 0) begin
				// row 0 acts as a unit coin
				for (int j = 0; j <= t; j++)
					min_coins[0][j] = j;
				for (int i = 1; i <= n; i++) begin
					c = int'(shadow_coins[i-1]);
					for (int j = 0; j <= t; j++) begin
						v = min_coins[i-1][j];
						if (c != 0 && j >= c && min_coins[i][j-c] + 1 < v)
							v = min_coins[i][j-c] + 1;
						min_coins[i][j] = v;
					end
				end
				// walk back from the last coin slot in use
				d = n;
				walking = 1'b1;
				while (walking && d > 0) begin
					c = int'(shadow_coins[d-1]);
					if (c != 1 && min_coins[d][t] == min_coins[d-1][t]) begin
						d--;
					end else if (c != 0 && t >= c &&
						min_coins[d][t] == min_coins[d][t-c] + 1) begin
						taken[d-1]++;
						t -= c;
					end else begin
						walking = 1'b0;
					end
				end
				if (record) begin
					for (int k = 0; k < n; k++) begin
						s = n - 1 - k;
						r.denomination = shadow_coins[s];
						r.coins_used   = CNT_W'(taken[s]);
						r.last         = (s == 0);
						change_due.push_back(r);
					end
				end
			end
		end
	endfunction

	function automatic script_row_t row(row_kind_t kind, int a, int b = 0, bit typed = 1'b0,
		bit typed_n = 1'b0, int denom = 0, int cnt = 0);
		script_row_t x;
		x.kind                   = kind;
		x.arg_a                  = 10'(a);
		x.arg_b                  = 10'(b);
		x.typed                  = typed;
		x.typed_n                = typed_n;
		x.typed_out.denomination = VAL_W'(denom);
		x.typed_out.coins_used   = CNT_W'(cnt);
		x.typed_out.last         = 1'b1;
		return x;
	endfunction

	// present one input beat, hold it until accepted, then predict
	task automatic send_beat(input in_beat_t b, input bit typed = 1'b0,
		input bit typed_n = 1'b0, input out_beat_t typed_out = '0);
		int gap;
		if (gap_pct != 0 && int'($urandom_range(99, 0)) < gap_pct) begin
			in_valid <= 1'b0;
			gap = int'($urandom_range(18, 1));
			repeat (gap) @(posedge clk);
		end
		in_data  <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_beat(b, !typed);
		if (typed && typed_n)
			change_due.push_back(typed_out);
	endtask

	// hold off the sender until every result has come and the block is idle
	task automatic settle();
		in_valid <= 1'b0;
		while (change_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// setup cycle then access cycle
	task automatic write_kinds(input int kinds);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_COIN_KINDS, 2'b00};
		pwdata  <= PDATA_W'(kinds);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		shadow_kinds = KINDS_W'(kinds);
	endtask

	initial begin
		in_beat_t b;
		int prev, kinds, seg;

		// coin table filled first so no request reads an unwritten slot
		script = '{
			row(ROW_LOAD, 0, 1),
			row(ROW_LOAD, 1, 5),
			row(ROW_LOAD, 2, 10),
			row(ROW_LOAD, 3, 25),
			row(ROW_LOAD, 4, 50),
			row(ROW_LOAD, 5, 100),
			row(ROW_LOAD, 6, 500),
			row(ROW_LOAD, 7, 1023),
			row(ROW_CHANGE, 0, 0, 1'b1, 1'b1, 1, 0),
			row(ROW_CHANGE, 1023, 0, 1'b1, 1'b1, 1, 1023),
			row(ROW_KINDS, 8),
			row(ROW_CHANGE, 1023),
			row(ROW_CHANGE, 0),
			row(ROW_CHANGE, 63),
			row(ROW_KINDS, 0),
			row(ROW_CHANGE, 7, 0, 1'b1, 1'b0),
			row(ROW_KINDS, 15),
			row(ROW_CHANGE, 300),
			row(ROW_KINDS, 3),
			row(ROW_LOAD, 2, 0),
			row(ROW_CHANGE, 37),
			row(ROW_LOAD, 2, 10)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		gap_pct   = 25;
		stall_pct = 25;
		foreach (script[r]) begin
			case (script[r].kind)
			ROW_KINDS: begin
				settle();
				write_kinds(int'(script[r].arg_a));
			end
			ROW_LOAD: begin
				b.mode       = MODE_LOAD;
				b.coin_slot  = script[r].arg_a[SLOT_W-1:0];
				b.coin_value = script[r].arg_b;
				b.amount     = VAL_W'($urandom_range(TOP_AMOUNT, 0));
				send_beat(b);
			end
			default: begin
				b.mode       = MODE_CHANGE;
				b.coin_slot  = SLOT_W'($urandom_range(7, 0));
				b.coin_value = VAL_W'($urandom_range(TOP_AMOUNT, 0));
				b.amount     = script[r].arg_a;
				send_beat(b, script[r].typed, script[r].typed_n, script[r].typed_out);
			end
			endcase
		end

		// random part in segments, each with its own coin_kinds setting
		for (seg = 0; seg < 8; seg++) begin
			case (seg)
			0, 6: kinds = 8;
			1: kinds = 1;
			3: kinds = 15;
			7: kinds = int'($urandom_range(14, 9));
			default: kinds = int'($urandom_range(8, 1));
			endcase
			gap_pct   = (seg >= 6 || seg == 2) ? 0 : 30;
			stall_pct = (seg >= 6 || seg == 4) ? 0 : 30;
			settle();
			write_kinds(kinds);

			// well-formed ascending coin set on odd segments
			if (seg % 2 == 1) begin
				prev = 0;
				for (int k = 0; k < COIN_SLOTS; k++) begin
					if (k == 0)
						prev = ($urandom_range(3, 0) == 0) ? int'($urandom_range(6, 2)) : 1;
					else
						prev = prev + int'($urandom_range(4 + 8 * k, 1));
					if (prev > TOP_AMOUNT)
						prev = TOP_AMOUNT;
					b.mode       = MODE_LOAD;
					b.coin_slot  = SLOT_W'(k);
					b.coin_value = VAL_W'(prev);
					b.amount     = VAL_W'($urandom_range(TOP_AMOUNT, 0));
					send_beat(b);
				end
			end

			// mostly change requests with small amounts, a few over the full range
			for (int k = (seg % 2 == 1) ? 8 : 0; k < 12; k++) begin
				b.coin_slot  = SLOT_W'($urandom_range(7, 0));
				b.coin_value = VAL_W'($urandom_range(TOP_AMOUNT, 0));
				b.amount     = VAL_W'($urandom_range(TOP_AMOUNT, 0));
				if ($urandom_range(99, 0) < 30) begin
					b.mode = MODE_LOAD;
					case ($urandom_range(19, 0))
					0: b.coin_value = '0;
					1, 2, 3, 4, 5, 6, 7, 8, 9: b.coin_value = VAL_W'($urandom_range(30, 1));
					default: b.coin_value = VAL_W'($urandom_range(TOP_AMOUNT, 1));
					endcase
				end else begin
					b.mode = MODE_CHANGE;
					if ($urandom_range(9, 0) != 0)
						b.amount = VAL_W'($urandom_range(80, 0));
				end
				send_beat(b);
			end
		end

		settle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
